// File: rtl/quad_right_angle_energy_macros.svh
// Assertion macros shared by the quad right-angle energy block.
`ifndef QUAD_RIGHT_ANGLE_ENERGY_MACROS_SVH
`define QUAD_RIGHT_ANGLE_ENERGY_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define QRAE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define QRAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/qrae_pkg.sv
// Shared types, constants and the arctangent table of the quad right-angle energy block.
package qrae_pkg;

	// CORDIC and angle formats (angles are signed Q.24 radians).
	localparam int CORDIC_ITERS = 24;
	localparam int XW           = 61;
	localparam int ANG_W        = 28;
	localparam int T_W          = 30;
	localparam int DEV_W        = 27;
	localparam int SQ_W         = 2 * DEV_W;
	localparam int SUM_W        = SQ_W + 2;
	localparam int ENERGY_W     = 20;
	localparam int STATUS_W     = 2;
	localparam int PI_Q         = 52707179;
	localparam int TWO_PI_Q     = 2 * PI_Q;
	localparam int HALF_PI_Q    = 26353589;
	localparam int DEGEN_Q      = 128;
	localparam int ENERGY_MAX   = 1048575;

	// Pipeline depths of the lane and of the merging stage.
	localparam int LANE_LAT  = CORDIC_ITERS + 2;
	localparam int MERGE_LAT = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NOT_CONVEX = 2'd1,
		ST_DEGENERATE = 2'd2
	} status_t;

	// What one lane hands to the merging stage.
	typedef struct packed {
		logic                    gate_ok;
		logic signed [ANG_W-1:0] ang;
	} lane_res_t;

	// round(atan(2^-i) * 2^24)
	function automatic logic signed [ANG_W-1:0] atan_q(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0:  r = 28'sd13176795;
			1:  r = 28'sd7778716;
			2:  r = 28'sd4110060;
			3:  r = 28'sd2086331;
			4:  r = 28'sd1047214;
			5:  r = 28'sd524117;
			6:  r = 28'sd262123;
			7:  r = 28'sd131069;
			8:  r = 28'sd65536;
			9:  r = 28'sd32768;
			10: r = 28'sd16384;
			11: r = 28'sd8192;
			12: r = 28'sd4096;
			13: r = 28'sd2048;
			14: r = 28'sd1024;
			15: r = 28'sd512;
			16: r = 28'sd256;
			17: r = 28'sd128;
			18: r = 28'sd64;
			19: r = 28'sd32;
			20: r = 28'sd16;
			21: r = 28'sd8;
			22: r = 28'sd4;
			23: r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/quad_right_angle_energy.sv
// Quad right-angle energy: four-lane pipelined evaluator, top level.
// Takes one quad (corners a, b, c, d) per cycle unless stalled and returns one word per quad
// holding the sum of squared deviations of its interior angles from pi/2
// (unsigned Q4.16, saturating) and a status: 0 valid, 1 not strictly convex
// counter-clockwise, 2 a corner angle within 2^-17 rad of 0 or pi. The edge
// vectors are registered first, then the convexity cross products and CORDIC
// setup, then the per-edge CORDIC pipelines (one iteration a stage, four lanes
// side by side) and last the merge stages. The whole pipeline advances
// whenever the output register is empty or being taken, so a full stream
// sustains one quad per cycle.
`include "quad_right_angle_energy_macros.svh"
module quad_right_angle_energy #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [COORD_WIDTH-1:0]  ax,
	input  logic signed [COORD_WIDTH-1:0]  ay,
	input  logic signed [COORD_WIDTH-1:0]  bx,
	input  logic signed [COORD_WIDTH-1:0]  by,
	input  logic signed [COORD_WIDTH-1:0]  cx,
	input  logic signed [COORD_WIDTH-1:0]  cy,
	input  logic signed [COORD_WIDTH-1:0]  dx,
	input  logic signed [COORD_WIDTH-1:0]  dy,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [qrae_pkg::ENERGY_W-1:0]  energy,
	output logic [qrae_pkg::STATUS_W-1:0]  status
);
	import qrae_pkg::*;

	localparam int EW    = COORD_WIDTH + 1;
	localparam int DEPTH = 1 + LANE_LAT + MERGE_LAT;

	logic                  en;
	logic [DEPTH-1:0]      vld_q;
	logic signed [EW-1:0]  ex_s1 [4];
	logic signed [EW-1:0]  ey_s1 [4];
	lane_res_t             res [4];
	status_t               st;

	assign en       = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = en;

	// Word valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// Edge vectors ab, bc, cd, da.
	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1[0] <= EW'(bx) - EW'(ax);
			ey_s1[0] <= EW'(by) - EW'(ay);
			ex_s1[1] <= EW'(cx) - EW'(bx);
			ey_s1[1] <= EW'(cy) - EW'(by);
			ex_s1[2] <= EW'(dx) - EW'(cx);
			ey_s1[2] <= EW'(dy) - EW'(cy);
			ex_s1[3] <= EW'(ax) - EW'(dx);
			ey_s1[3] <= EW'(ay) - EW'(dy);
		end
	end

	// Four lanes, one per edge.
	for (genvar k = 0; k < 4; k++) begin : g_lane
		qrae_lane #(.CW(COORD_WIDTH)) u_lane (
			.clk (clk),
			.en  (en),
			.ex  (ex_s1[k]),
			.ey  (ey_s1[k]),
			.nx  (ex_s1[(k+1)%4]),
			.ny  (ey_s1[(k+1)%4]),
			.res (res[k])
		);
	end

	qrae_merge u_merge (
		.clk    (clk),
		.en     (en),
		.res    (res),
		.energy (energy),
		.status (st)
	);

	assign status    = st;
	assign out_valid = vld_q[DEPTH-1];

	`QRAE_ASSERT_NOW(a_fail_zero, clk, arst_n, out_valid && (status != ST_OK), energy == '0, "failed quad carries nonzero energy")
	`QRAE_ASSERT_NOW(a_stall_full, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled without a waiting word")
	`QRAE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(energy) && $stable(status), "stalled word changed")

endmodule

// File: rtl/qrae_lane.sv
// One lane: convexity test at a corner and CORDIC direction of the outgoing edge.
module qrae_lane #(
	parameter int CW = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [CW:0]      ex,
	input  logic signed [CW:0]      ey,
	input  logic signed [CW:0]      nx,
	input  logic signed [CW:0]      ny,
	output qrae_pkg::lane_res_t     res
);
	import qrae_pkg::*;

	localparam int EW       = CW + 1;
	localparam int PW       = 2 * EW;
	localparam int PRESCALE = 56 - CW;

	logic signed [PW-1:0]    p1_s2, p2_s2;
	logic signed [EW-1:0]    ex_s2, ey_s2;
	logic signed [PW:0]      xprod;
	logic signed [XW-1:0]    xe, ye;
	logic signed [XW-1:0]    cx_s [CORDIC_ITERS+1];
	logic signed [XW-1:0]    cy_s [CORDIC_ITERS+1];
	logic signed [ANG_W-1:0] cz_s [CORDIC_ITERS+1];
	logic                    gate_s [CORDIC_ITERS+1];

	// Cross product partial products of this edge and the next one.
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2 <= ex * ny;
			p2_s2 <= ey * nx;
			ex_s2 <= ex;
			ey_s2 <= ey;
		end
	end

	assign xprod = {p1_s2[PW-1], p1_s2} - {p2_s2[PW-1], p2_s2};
	assign xe    = {{(XW-EW){ex_s2[EW-1]}}, ex_s2};
	assign ye    = {{(XW-EW){ey_s2[EW-1]}}, ey_s2};

	// Gate bit and CORDIC start: turn the edge into the right half plane, then prescale.
	always_ff @(posedge clk) begin
		if (en) begin
			gate_s[0] <= (xprod > 0);
			if (ex_s2 < 0) begin
				cx_s[0] <= (-xe) <<< PRESCALE;
				cy_s[0] <= (-ye) <<< PRESCALE;
				cz_s[0] <= ANG_W'(PI_Q);
			end else begin
				cx_s[0] <= xe <<< PRESCALE;
				cy_s[0] <= ye <<< PRESCALE;
				cz_s[0] <= '0;
			end
		end
	end

	// One vectoring iteration per pipeline stage.
	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				gate_s[i+1] <= gate_s[i];
				if (cy_s[i] < 0) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - atan_q(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + atan_q(i);
				end
			end
		end
	end

	assign res.gate_ok = gate_s[CORDIC_ITERS];
	assign res.ang     = cz_s[CORDIC_ITERS];

endmodule

// File: rtl/qrae_merge.sv
// Merging stage: interior angles, squared deviations, sum and status.
module qrae_merge (
	input  logic                         clk,
	input  logic                         en,
	input  qrae_pkg::lane_res_t          res [4],
	output logic [qrae_pkg::ENERGY_W-1:0] energy,
	output qrae_pkg::status_t            status
);
	import qrae_pkg::*;

	localparam logic signed [T_W-1:0] PI_T     = T_W'(PI_Q);
	localparam logic signed [T_W-1:0] TWO_PI_T = T_W'(TWO_PI_Q);
	localparam logic signed [T_W-1:0] HALF_T   = T_W'(HALF_PI_Q);
	localparam logic signed [T_W-1:0] DEG_LO   = T_W'(DEGEN_Q);
	localparam logic signed [T_W-1:0] DEG_HI   = T_W'(PI_Q - DEGEN_Q);
	localparam int                    RND_W    = SUM_W - 32;

	logic signed [DEV_W-1:0] dev_c [4];
	logic [3:0]              degen_c;
	logic signed [DEV_W-1:0] dev_s1 [4];
	status_t                 st_s1, st_s2;
	logic [SQ_W-1:0]         sq_s2 [4];
	logic [SUM_W-1:0]        sum;
	logic [RND_W-1:0]        rnd;
	logic [ENERGY_W-1:0]     energy_q;
	status_t                 status_q;

	// Interior angle at each corner, reduced to [0, 2*pi) and folded to [0, pi].
	always_comb begin
		logic signed [T_W-1:0] t;
		for (int k = 0; k < 4; k++) begin
			t = {{(T_W-ANG_W){res[k].ang[ANG_W-1]}}, res[k].ang}
				- {{(T_W-ANG_W){res[(k+1)%4].ang[ANG_W-1]}}, res[(k+1)%4].ang} + PI_T;
			if (t < 0)
				t = t + TWO_PI_T;
			else if (t >= TWO_PI_T)
				t = t - TWO_PI_T;
			if (t > PI_T)
				t = TWO_PI_T - t;
			degen_c[k] = (t < DEG_LO) || (t > DEG_HI);
			dev_c[k]   = DEV_W'(t - HALF_T);
		end
	end

	// Deviations and status.
	always_ff @(posedge clk) begin
		if (en) begin
			dev_s1 <= dev_c;
			if (!(res[0].gate_ok && res[1].gate_ok && res[2].gate_ok && res[3].gate_ok))
				st_s1 <= ST_NOT_CONVEX;
			else if (|degen_c)
				st_s1 <= ST_DEGENERATE;
			else
				st_s1 <= ST_OK;
		end
	end

	// Exact squares.
	always_ff @(posedge clk) begin
		if (en) begin
			st_s2 <= st_s1;
			for (int k = 0; k < 4; k++)
				sq_s2[k] <= SQ_W'(dev_s1[k] * dev_s1[k]);
		end
	end

	// Sum, round half up to Q.16, saturate; a failed quad gets zero energy.
	assign sum = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2])
		+ SUM_W'(sq_s2[3]) + (SUM_W'(1) << 31);
	assign rnd = sum[SUM_W-1:32];

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= st_s2;
			if (st_s2 != ST_OK)
				energy_q <= '0;
			else if (rnd > RND_W'(ENERGY_MAX))
				energy_q <= ENERGY_W'(ENERGY_MAX);
			else
				energy_q <= rnd[ENERGY_W-1:0];
		end
	end

	assign energy = energy_q;
	assign status = status_q;

endmodule

// File: test/tb_quad_right_angle_energy.sv
// Self-checking testbench for the quad right-angle energy block.
module tb_quad_right_angle_energy;
	timeunit 1ns;
	timeprecision 1ps;
	import qrae_pkg::*;

	localparam int CW        = 16;
	localparam int N_RANDOM  = 1150;
	localparam int LIMIT     = 600000;
	localparam int DRAIN     = 40;
	localparam int SCALE_SH  = 56 - CW;

	typedef struct packed {
		logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	} quad_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		status_t             st;
	} energy_word_t;

	typedef struct {
		quad_t        q;
		bit           typed;
		energy_word_t w;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] ax = '0, ay = '0, bx = '0, by = '0;
	logic signed [CW-1:0] cx = '0, cy = '0, dx = '0, dy = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ENERGY_W-1:0] energy;
	logic [STATUS_W-1:0] status;

	energy_word_t pending_words[$];
	vec_row_t     vec_rows[$];
	int           n_sent = 0;
	int           n_recv = 0;
	int           n_errors = 0;
	int           n_status[3] = '{0, 0, 0};
	int           cycles = 0;
	bit           rx_hold_done = 1'b0;

	// Arctangent steps in Q.24 radians.
	const longint angle_step[24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	quad_right_angle_energy #(.COORD_WIDTH(CW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy), .dx(dx), .dy(dy),
		.out_valid(out_valid), .out_ready(out_ready),
		.energy(energy), .status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("quad_right_angle_energy verification failed");
			$finish;
		end
	end

	// Direction of one edge by CORDIC vectoring, Q.24 radians.
	function automatic longint edge_direction(input longint x, input longint y);
		longint z, sx, sy;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = longint'(PI_Q);
		end
		x = x * (longint'(1) <<< SCALE_SH);
		y = y * (longint'(1) <<< SCALE_SH);
		for (int i = 0; i < 24; i++) begin
			sx = y >>> i;
			sy = x >>> i;
			if (y < 0) begin
				x = x - sx;
				y = y + sy;
				z = z - angle_step[i];
			end else begin
				x = x + sx;
				y = y - sy;
				z = z + angle_step[i];
			end
		end
		return z;
	endfunction

	// Energy word expected for one quad.
	function automatic energy_word_t quad_energy(input quad_t q);
		longint px[4], py[4], ex[4], ey[4], dir[4];
		longint t, dev, sum, e;
		int n;
		energy_word_t w;
		px = '{q.ax, q.bx, q.cx, q.dx};
		py = '{q.ay, q.by, q.cy, q.dy};
		w.st = ST_OK;
		sum = 0;
		for (int k = 0; k < 4; k++) begin
			n = (k + 1) % 4;
			ex[k] = px[n] - px[k];
			ey[k] = py[n] - py[k];
		end
		// Convexity gate: every turn strictly to the left.
		for (int k = 0; k < 4; k++) begin
			n = (k + 1) % 4;
			if (ex[k] * ey[n] - ey[k] * ex[n] <= 0)
				w.st = ST_NOT_CONVEX;
		end
		if (w.st == ST_OK) begin
			for (int k = 0; k < 4; k++)
				dir[k] = edge_direction(ex[k], ey[k]);
			for (int k = 0; k < 4; k++) begin
				t = dir[k] - dir[(k + 1) % 4] + longint'(PI_Q);
				while (t < 0)
					t = t + longint'(TWO_PI_Q);
				while (t >= longint'(TWO_PI_Q))
					t = t - longint'(TWO_PI_Q);
				if (t > longint'(PI_Q))
					t = longint'(TWO_PI_Q) - t;
				if (t < longint'(DEGEN_Q) || t > longint'(PI_Q) - longint'(DEGEN_Q))
					w.st = ST_DEGENERATE;
				dev = t - longint'(HALF_PI_Q);
				sum = sum + dev * dev;
			end
		end
		if (w.st != ST_OK) begin
			w.energy = '0;
		end else begin
			e = (sum + (longint'(1) <<< 31)) >>> 32;
			if (e > longint'(ENERGY_MAX))
				e = longint'(ENERGY_MAX);
			w.energy = ENERGY_W'(e);
		end
		return w;
	endfunction

	function automatic quad_t mk_quad(input int a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y);
		quad_t q;
		q = '{CW'(a_x), CW'(a_y), CW'(b_x), CW'(b_y), CW'(c_x), CW'(c_y),
			CW'(d_x), CW'(d_y)};
		return q;
	endfunction

	task automatic add_row(input quad_t q, input bit typed, input status_t st);
		vec_row_t r;
		r.q = q;
		r.typed = typed;
		r.w.energy = '0;
		r.w.st = st;
		vec_rows = {vec_rows, r};
	endtask

	// Random convex counter-clockwise quad: one corner on each side of a box.
	function automatic quad_t box_quad();
		int w, h, l, b;
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 65535) : $urandom_range(3, 200);
		h = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 65535) : $urandom_range(3, 200);
		l = -32768 + $urandom_range(0, 65535 - w);
		b = -32768 + $urandom_range(0, 65535 - h);
		// Corners are drawn as offsets so that the range stays valid below zero.
		return mk_quad(l + 1 + int'($urandom_range(0, w - 2)), b,
			l + w, b + 1 + int'($urandom_range(0, h - 2)),
			l + 1 + int'($urandom_range(0, w - 2)), b + h,
			l, b + 1 + int'($urandom_range(0, h - 2)));
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		int pick;
		pick = $urandom_range(0, 99);
		q = box_quad();
		if (pick < 75) begin
			return q;
		end else if (pick < 85) begin
			// Clockwise order of the same corners.
			return '{q.ax, q.ay, q.dx, q.dy, q.cx, q.cy, q.bx, q.by};
		end else if (pick < 90) begin
			// Two corners on the same spot.
			q.cx = q.bx;
			q.cy = q.by;
			return q;
		end
		return quad_t'({$urandom(), $urandom(), $urandom(), $urandom()});
	endfunction

	// Offer one word and record what it must produce once it is taken.
	task automatic send_quad(input quad_t q, input bit typed, input energy_word_t w);
		int gap;
		bit took;
		gap = ((n_sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{ax, ay, bx, by, cx, cy, dx, dy} <= q;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		pending_words = {pending_words, typed ? w : quad_energy(q)};
		n_sent++;
	endtask

	// Receiver: random stalls, one long hold-off so the pipeline backs up.
	initial begin
		int gap;
		bit took;
		@(posedge arst_n);
		forever begin
			gap = ((n_recv / 50) % 3 == 2) ? 0 : $urandom_range(0, 14);
			if (!rx_hold_done && n_recv >= 200) begin
				gap = 300;
				rx_hold_done = 1'b1;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				took = out_valid;
				@(posedge clk);
			end while (!took);
		end
	end

	// Compare every delivered word with the oldest expectation.
	always @(negedge clk) begin
		energy_word_t w;
		if (arst_n && out_valid && out_ready) begin
			n_recv++;
			if (status < 3)
				n_status[status]++;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word energy=%0d status=%0d", $realtime, energy, status);
				n_errors++;
			end else begin
				w = pending_words.pop_front();
				if (energy !== w.energy) begin
					$display("%0t: energy expected %0d actual %0d", $realtime, w.energy, energy);
					n_errors++;
				end
				if (status !== w.st) begin
					$display("%0t: status expected %0d actual %0d", $realtime, w.st, status);
					n_errors++;
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed quads; the typed ones fail the convexity gate.
		add_row(mk_quad(0, 0, 0, 0, 0, 0, 0, 0), 1, ST_NOT_CONVEX);
		add_row(mk_quad(0, 0, 0, 10, 10, 10, 10, 0), 1, ST_NOT_CONVEX);
		add_row(mk_quad(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768),
			1, ST_NOT_CONVEX);
		add_row(mk_quad(0, 0, 5, 5, 10, 10, 0, 10), 1, ST_NOT_CONVEX);
		add_row(mk_quad(0, 0, 10, 0, 10, 0, 0, 10), 1, ST_NOT_CONVEX);
		add_row(mk_quad(0, 0, 10, 10, 10, 0, 0, 10), 1, ST_NOT_CONVEX);
		add_row(mk_quad(0, 0, 10, 0, 3, 3, 0, 10), 1, ST_NOT_CONVEX);
		add_row(mk_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767),
			0, ST_OK);
		add_row(mk_quad(0, 0, 1, 0, 1, 1, 0, 1), 0, ST_OK);
		add_row(mk_quad(-1, -1, 0, -1, 0, 0, -1, 0), 0, ST_OK);
		add_row(mk_quad(-100, -7, 3000, -7, 3000, 40, -100, 40), 0, ST_OK);
		add_row(mk_quad(0, -32768, 32767, 0, 0, 32767, -32768, 0), 0, ST_OK);
		add_row(mk_quad(0, -1, 32767, 0, 0, 32767, -32768, 0), 0, ST_OK);
		add_row(mk_quad(-32768, -32768, 32766, 32765, 32767, 32766, -32768, 32767),
			0, ST_OK);
		add_row(mk_quad(-32768, -32768, 32767, -32768, 32767, -32767, -32767, -32767),
			0, ST_OK);
		add_row(mk_quad(-32768, 0, 0, -1, 32767, 0, 0, 1), 0, ST_OK);
		add_row(mk_quad(-5, -5, 32767, 32766, 32766, 32767, -6, -4), 0, ST_OK);
		add_row(mk_quad(21845, -21846, 21845, 21845, -21846, 21845, -21846, -21846),
			0, ST_OK);
		foreach (vec_rows[i])
			send_quad(vec_rows[i].q, vec_rows[i].typed, vec_rows[i].w);

		// Random part, mostly well-formed quads.
		for (int i = 0; i < N_RANDOM; i++)
			send_quad(random_quad(), 0, '0);
		in_valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d quads sent, %0d words checked: %0d valid, %0d non-convex, %0d degenerate",
			n_sent, n_recv, n_status[0], n_status[1], n_status[2]);
		$display("long output hold-off applied: %0d, mismatches: %0d", rx_hold_done, n_errors);
		if (n_errors == 0)
			$display("quad_right_angle_energy verification clean");
		else
			$display("quad_right_angle_energy verification failed");
		$finish;
	end

endmodule
